/* rtl/core/atrp_pkg.sv */
// shared types and constants for the accelerometer tilt pipeline
// no dependencies

package atrp_pkg;

    localparam int ANGLE_FRAC_BITS = 7;
    localparam int CORDIC_STEPS    = 16;
    localparam int ACC_FRAC        = 20;
    localparam int IN_SHIFT        = 14;
    localparam int VEC_W           = 34;
    localparam int ANG_W           = 32;
    localparam int RAW_W           = 16;
    localparam int ROLL_W          = 16;
    localparam int PITCH_W         = 15;
    localparam int GAIN_SHIFT      = 30;
    localparam int PROD_W          = 62;
    localparam int TABLE_LEN       = 24;

    localparam logic [29:0] INV_GAIN_Q30 = 30'd652032875;

    localparam logic signed [ANG_W-1:0] ATAN_Q20 [TABLE_LEN] = '{
        32'sd47185920, 32'sd27855475, 32'sd14718068, 32'sd7471121,
        32'sd3750058,  32'sd1876857,  32'sd938658,   32'sd469357,
        32'sd234682,   32'sd117342,   32'sd58671,    32'sd29335,
        32'sd14668,    32'sd7334,     32'sd3667,     32'sd1833,
        32'sd917,      32'sd458,      32'sd229,      32'sd115,
        32'sd57,       32'sd29,       32'sd14,       32'sd7
    };

    // fields that ride alongside the cordic vectors
    typedef struct packed {
        logic                    zero;
        logic signed [RAW_W-1:0] fwd;
        logic signed [ANG_W-1:0] roll_z;
    } side_t;

endpackage

/* rtl/core/atrp_cordic.sv */
// vectoring cordic, one register stage per step
// depends on atrp_pkg

module atrp_cordic (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic signed [atrp_pkg::VEC_W-1:0]    in_x,
    input  logic signed [atrp_pkg::VEC_W-1:0]    in_y,
    input  logic signed [atrp_pkg::ANG_W-1:0]    in_z,
    input  atrp_pkg::side_t                      in_side,
    output logic                                 out_valid,
    output logic signed [atrp_pkg::VEC_W-1:0]    out_x,
    output logic signed [atrp_pkg::ANG_W-1:0]    out_z,
    output atrp_pkg::side_t                      out_side
);
    import atrp_pkg::*;

    logic                    v_reg [1:CORDIC_STEPS];
    logic signed [VEC_W-1:0] x_reg [1:CORDIC_STEPS];
    logic signed [VEC_W-1:0] y_reg [1:CORDIC_STEPS];
    logic signed [ANG_W-1:0] z_reg [1:CORDIC_STEPS];
    side_t                   s_reg [1:CORDIC_STEPS];

    genvar i;
    generate
        for (i = 0; i < CORDIC_STEPS; i++) begin : g_step
            logic                    vi;
            logic signed [VEC_W-1:0] xi;
            logic signed [VEC_W-1:0] yi;
            logic signed [ANG_W-1:0] zi;
            side_t                   si;
            logic signed [VEC_W-1:0] x_next;
            logic signed [VEC_W-1:0] y_next;
            logic signed [ANG_W-1:0] z_next;

            if (i == 0) begin : g_first
                assign vi = in_valid;
                assign xi = in_x;
                assign yi = in_y;
                assign zi = in_z;
                assign si = in_side;
            end else begin : g_rest
                assign vi = v_reg[i];
                assign xi = x_reg[i];
                assign yi = y_reg[i];
                assign zi = z_reg[i];
                assign si = s_reg[i];
            end

            // y >= 0 rotates clockwise and adds the table angle
            always_comb
            begin
                if (!yi[VEC_W-1])
                begin
                    x_next = xi + (yi >>> i);
                    y_next = yi - (xi >>> i);
                    z_next = zi + ATAN_Q20[i];
                end
                else
                begin
                    x_next = xi - (yi >>> i);
                    y_next = yi + (xi >>> i);
                    z_next = zi - ATAN_Q20[i];
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[i+1] <= 1'b0;
                end
                else if (en)
                begin
                    v_reg[i+1] <= vi;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x_reg[i+1] <= x_next;
                    y_reg[i+1] <= y_next;
                    z_reg[i+1] <= z_next;
                    s_reg[i+1] <= si;
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[CORDIC_STEPS];
    assign out_x     = x_reg[CORDIC_STEPS];
    assign out_z     = z_reg[CORDIC_STEPS];
    assign out_side  = s_reg[CORDIC_STEPS];

endmodule

/* rtl/core/atrp_gain.sv */
// cordic gain correction: registered product, rounded magnitude out
// depends on atrp_pkg

module atrp_gain (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic signed [atrp_pkg::VEC_W-1:0]    in_x,
    input  logic signed [atrp_pkg::ANG_W-1:0]    in_z,
    input  atrp_pkg::side_t                      in_side,
    output logic                                 out_valid,
    output logic signed [atrp_pkg::VEC_W-1:0]    out_mag,
    output atrp_pkg::side_t                      out_side
);
    import atrp_pkg::*;

    logic              valid_reg;
    logic [PROD_W-1:0] prod_reg;
    side_t             side_reg;
    side_t             side_next;
    logic [PROD_W-1:0] prod_round;

    // x is never negative after vectoring and stays below 2^31
    always_comb
    begin
        side_next        = in_side;
        side_next.roll_z = in_z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= PROD_W'(in_x[31:0]) * PROD_W'(INV_GAIN_Q30);
            side_reg <= side_next;
        end
    end

    assign prod_round = prod_reg + (PROD_W'(1) << (GAIN_SHIFT - 1));
    assign out_mag    = VEC_W'(prod_round >> GAIN_SHIFT);
    assign out_valid  = valid_reg;
    assign out_side   = side_reg;

endmodule

/* rtl/core/accel_tilt_roll_pitch_top.sv */
// pipeline: prerotate, 16 roll cordic steps, gain multiply, 16 pitch cordic
// steps and output rounding, each a register stage
// throughput: one beat per cycle; the whole pipe holds while a result is stalled
// reset: async active-low rst_n clears all valid bits; no clearing pass
// depends on atrp_pkg, atrp_cordic, atrp_gain

module accel_tilt_roll_pitch_top (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [atrp_pkg::RAW_W-1:0]      raw_x,
    input  logic signed [atrp_pkg::RAW_W-1:0]      raw_y,
    input  logic signed [atrp_pkg::RAW_W-1:0]      raw_z,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [atrp_pkg::ROLL_W-1:0]     roll_angle,
    output logic signed [atrp_pkg::PITCH_W-1:0]    pitch_angle
);
    import atrp_pkg::*;

    localparam int RND_SHIFT = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam int ONE       = 1 << ANGLE_FRAC_BITS;
    localparam logic signed [ANG_W:0] ROLL_LIM  = (ANG_W+1)'(180 * ONE);
    localparam logic signed [ANG_W:0] PITCH_LIM = (ANG_W+1)'(90 * ONE);
    localparam logic signed [ANG_W-1:0] QUARTER = ANG_W'(90) <<< ACC_FRAC;

    // pipe advances unless a finished result is waiting
    logic out_valid_reg;
    logic en;
    assign en       = !out_valid_reg || !out_stall;
    assign in_stall = !en;

    // stage 0: scale and pre-rotate into the right half plane
    logic                    pre_valid_reg;
    logic signed [VEC_W-1:0] pre_x_reg;
    logic signed [VEC_W-1:0] pre_y_reg;
    logic signed [ANG_W-1:0] pre_z_reg;
    side_t                   pre_side_reg;

    logic signed [VEC_W-1:0] up_s;
    logic signed [VEC_W-1:0] side_s;
    logic signed [VEC_W-1:0] pre_x_next;
    logic signed [VEC_W-1:0] pre_y_next;
    logic signed [ANG_W-1:0] pre_z_next;
    side_t                   pre_side_next;

    assign up_s   = VEC_W'(raw_x) <<< IN_SHIFT;
    assign side_s = VEC_W'(raw_y) <<< IN_SHIFT;

    always_comb
    begin
        pre_x_next = up_s;
        pre_y_next = side_s;
        pre_z_next = '0;
        if (up_s[VEC_W-1])
        begin
            if (!side_s[VEC_W-1])
            begin
                pre_x_next = side_s;
                pre_y_next = -up_s;
                pre_z_next = QUARTER;
            end
            else
            begin
                pre_x_next = -side_s;
                pre_y_next = up_s;
                pre_z_next = -QUARTER;
            end
        end
        pre_side_next.zero   = (raw_x == '0) && (raw_y == '0);
        pre_side_next.fwd    = raw_z;
        pre_side_next.roll_z = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            pre_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pre_x_reg    <= pre_x_next;
            pre_y_reg    <= pre_y_next;
            pre_z_reg    <= pre_z_next;
            pre_side_reg <= pre_side_next;
        end
    end

    // roll cordic on (up, side)
    logic                    r_valid;
    logic signed [VEC_W-1:0] r_x;
    logic signed [ANG_W-1:0] r_z;
    side_t                   r_side;

    atrp_cordic u_roll (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pre_valid_reg),
        .in_x      (pre_x_reg),
        .in_y      (pre_y_reg),
        .in_z      (pre_z_reg),
        .in_side   (pre_side_reg),
        .out_valid (r_valid),
        .out_x     (r_x),
        .out_z     (r_z),
        .out_side  (r_side)
    );

    // magnitude of (up, side) with the cordic gain removed
    logic                    g_valid;
    logic signed [VEC_W-1:0] g_mag;
    side_t                   g_side;

    atrp_gain u_gain (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (r_valid),
        .in_x      (r_x),
        .in_z      (r_z),
        .in_side   (r_side),
        .out_valid (g_valid),
        .out_mag   (g_mag),
        .out_side  (g_side)
    );

    // pitch cordic on (magnitude, forward)
    logic                    p_valid;
    logic signed [VEC_W-1:0] p_x;
    logic signed [ANG_W-1:0] p_z;
    side_t                   p_side;
    logic signed [VEC_W-1:0] fwd_s;

    assign fwd_s = VEC_W'(g_side.fwd) <<< IN_SHIFT;

    atrp_cordic u_pitch (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (g_valid),
        .in_x      (g_mag),
        .in_y      (fwd_s),
        .in_z      ('0),
        .in_side   (g_side),
        .out_valid (p_valid),
        .out_x     (p_x),
        .out_z     (p_z),
        .out_side  (p_side)
    );

    // output stage: round to nearest (ties up), clamp, zero-vector case
    logic signed [ROLL_W-1:0]  roll_reg;
    logic signed [PITCH_W-1:0] pitch_reg;
    logic signed [ROLL_W-1:0]  roll_next;
    logic signed [PITCH_W-1:0] pitch_next;
    logic signed [ANG_W:0]     roll_neg;
    logic signed [ANG_W:0]     roll_rnd;
    logic signed [ANG_W:0]     pitch_rnd;
    logic                      unused_x;

    // pitch magnitude is not needed
    assign unused_x = ^p_x;

    always_comb
    begin
        roll_neg  = -((ANG_W+1)'(p_side.roll_z));
        roll_rnd  = (roll_neg + ((ANG_W+1)'(1) <<< (RND_SHIFT - 1))) >>> RND_SHIFT;
        pitch_rnd = ((ANG_W+1)'(p_z) + ((ANG_W+1)'(1) <<< (RND_SHIFT - 1))) >>> RND_SHIFT;

        if (roll_rnd > ROLL_LIM)
            roll_next = ROLL_W'(ROLL_LIM);
        else if (roll_rnd < -ROLL_LIM)
            roll_next = ROLL_W'(-ROLL_LIM);
        else
            roll_next = ROLL_W'(roll_rnd);

        if (pitch_rnd > PITCH_LIM)
            pitch_next = PITCH_W'(PITCH_LIM);
        else if (pitch_rnd < -PITCH_LIM)
            pitch_next = PITCH_W'(-PITCH_LIM);
        else
            pitch_next = PITCH_W'(pitch_rnd);

        // no up/side component: straight up or down
        if (p_side.zero)
        begin
            roll_next = '0;
            if (p_side.fwd > 0)
                pitch_next = PITCH_W'(-PITCH_LIM);
            else
                pitch_next = PITCH_W'(PITCH_LIM);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= p_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            roll_reg  <= roll_next;
            pitch_reg <= pitch_next ^ PITCH_W'(unused_x & 1'b0);
        end
    end

    assign out_valid   = out_valid_reg;
    assign roll_angle  = roll_reg;
    assign pitch_angle = pitch_reg;

endmodule

/* tb/sv/accel_tilt_roll_pitch_top_tb.sv */
// testbench for the accelerometer tilt pipeline: roll and pitch from one sample
// bit-exact cordic predictor, directed and random beats, random idle and stall
// depends on atrp_pkg and accel_tilt_roll_pitch_top
`timescale 1ns / 100ps

module accel_tilt_roll_pitch_top_tb;
    import atrp_pkg::*;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [RAW_W-1:0] raw_x;
    logic signed [RAW_W-1:0] raw_y;
    logic signed [RAW_W-1:0] raw_z;
    logic out_valid;
    logic out_stall;
    logic signed [ROLL_W-1:0] roll_angle;
    logic signed [PITCH_W-1:0] pitch_angle;

    // one predicted result beat
    typedef struct packed {
        logic [ROLL_W-1:0]  roll;
        logic [PITCH_W-1:0] pitch;
    } angles_t;

    angles_t angles_q[$];
    int      fail_cnt;
    int      idle_cycles;
    bit      stall_hold;

    localparam int WATCHDOG = 20000;
    localparam int DRAIN    = 80;

    accel_tilt_roll_pitch_top u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .raw_x(raw_x), .raw_y(raw_y), .raw_z(raw_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .roll_angle(roll_angle), .pitch_angle(pitch_angle)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // arithmetic right shift on 64 bits is already a floor shift
    function automatic longint vec_angle(inout longint x, input longint y,
                                         input longint z);
        longint dx;
        longint dy;
        for (int i = 0; i < CORDIC_STEPS && i < TABLE_LEN; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x = x + dx; y = y - dy; z = z + longint'(ATAN_Q20[i]);
            end
            else
            begin
                x = x - dx; y = y + dy; z = z - longint'(ATAN_Q20[i]);
            end
        end
        return z;
    endfunction

    // q20 degrees to output units, round half up, then clamp
    function automatic longint round_clamp(longint z, longint lim);
        longint v;
        v = (z + (longint'(1) << (ACC_FRAC - ANGLE_FRAC_BITS - 1)))
            >>> (ACC_FRAC - ANGLE_FRAC_BITS);
        if (v > lim) v = lim;
        if (v < -lim) v = -lim;
        return v;
    endfunction

    function automatic angles_t tilt_angles(logic signed [RAW_W-1:0] up,
                                            logic signed [RAW_W-1:0] sd,
                                            logic signed [RAW_W-1:0] fw);
        longint one;
        longint x;
        longint y;
        longint z;
        longint t;
        longint mag;
        longint rl;
        longint pt;
        angles_t r;
        one = longint'(1) << ANGLE_FRAC_BITS;
        if (up == 0 && sd == 0)
        begin
            // flat denominator: straight up or down
            rl = 0;
            pt = (fw > 0) ? -90 * one : 90 * one;
        end
        else
        begin
            x = longint'(up) <<< IN_SHIFT;
            y = longint'(sd) <<< IN_SHIFT;
            z = 0;
            if (x < 0)
            begin
                t = x;
                if (y >= 0)
                begin
                    x = y; y = -t; z = longint'(90) <<< ACC_FRAC;
                end
                else
                begin
                    x = -y; y = t; z = -(longint'(90) <<< ACC_FRAC);
                end
            end
            z = vec_angle(x, y, z);
            mag = (x * longint'(INV_GAIN_Q30) + (longint'(1) << 29)) >>> 30;
            t = vec_angle(mag, longint'(fw) <<< IN_SHIFT, 0);
            rl = round_clamp(-z, 180 * one);
            pt = round_clamp(t, 90 * one);
        end
        r.roll  = rl[ROLL_W-1:0];
        r.pitch = pt[PITCH_W-1:0];
        return r;
    endfunction

    // send one beat; sender works in bursts, with a random gap before each burst
    int burst_left;
    task automatic send_sample(logic signed [RAW_W-1:0] up,
                               logic signed [RAW_W-1:0] sd,
                               logic signed [RAW_W-1:0] fw);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        raw_x <= up;
        raw_y <= sd;
        raw_z <= fw;
        angles_q.push_back(tilt_angles(up, sd, fw));
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic send_idle();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // hold off until the pipe has drained
    task automatic wait_drained();
        send_idle();
        while (angles_q.size() != 0) @(posedge clk);
    endtask

    task automatic test_extremes();
        logic signed [RAW_W-1:0] ext[5];
        ext = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'sh0001, 16'shffff};
        // full-scale corners of all three axes
        foreach (ext[i]) send_sample(ext[i], ext[(i+1)%5], ext[(i+2)%5]);
        send_sample(16'sh8000, 16'sh8000, 16'sh8000);
        send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_sample(16'sh8000, 16'sh0000, 16'sh7fff);
        send_sample(16'sh0000, 16'sh8000, 16'sh0000);
    endtask

    task automatic test_zero_denominator();
        // up and side both zero: forward sign picks the pitch
        send_sample(16'sh0000, 16'sh0000, 16'sh0000);
        send_sample(16'sh0000, 16'sh0000, 16'sh0001);
        send_sample(16'sh0000, 16'sh0000, 16'shffff);
        send_sample(16'sh0000, 16'sh0000, 16'sh7fff);
        send_sample(16'sh0000, 16'sh0000, 16'sh8000);
    endtask

    task automatic test_prerotate();
        // negative up with each side sign, plus the axis boundaries
        send_sample(-16'sd1000, 16'sd0, 16'sd50);
        send_sample(-16'sd1000, -16'sd1, -16'sd50);
        send_sample(-16'sd1000, 16'sd1000, 16'sd0);
        send_sample(-16'sd1000, -16'sd1000, 16'sd16384);
        send_sample(16'sd16384, 16'sd0, 16'sd0);
        send_sample(16'sd0, 16'sd16384, -16'sd16384);
    endtask

    task automatic test_random(int n);
        logic signed [RAW_W-1:0] v[3];
        for (int i = 0; i < n; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                case ($urandom_range(0, 5))
                    0: v[k] = RAW_W'($signed($urandom_range(0, 8)) - 4);
                    1: v[k] = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
                    default: v[k] = RAW_W'($urandom);
                endcase
            end
            if ($urandom_range(0, 30) == 0)
            begin
                v[0] = '0; v[1] = '0;
            end
            send_sample(v[0], v[1], v[2]);
            if (i == n / 2)
                wait_drained();
        end
    endtask

    // receiver stall pattern: runs of stall and free time of random length
    initial
    begin
        int run;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            run = $urandom_range(1, 30);
            stall_hold = ($urandom_range(0, 2) == 0);
            repeat (run)
            begin
                @(posedge clk);
                out_stall <= stall_hold ? ($urandom_range(0, 1) == 0) : 1'b0;
            end
        end
    end

    // result checker; also counts cycles without any accepted beat
    always @(posedge clk)
    begin
        angles_t exp_a;
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (out_valid && !out_stall)
            begin
                if (angles_q.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected roll=%0d pitch=%0d",
                             $time, roll_angle, pitch_angle);
                    fail_cnt++;
                end
                else
                begin
                    exp_a = angles_q.pop_front();
                    if (roll_angle !== exp_a.roll)
                    begin
                        $display("%0t: roll_angle expected %0d actual %0d", $time,
                                 $signed(exp_a.roll), roll_angle);
                        fail_cnt++;
                    end
                    if (pitch_angle !== exp_a.pitch)
                    begin
                        $display("%0t: pitch_angle expected %0d actual %0d", $time,
                                 $signed(exp_a.pitch), pitch_angle);
                        fail_cnt++;
                    end
                end
            end
        end
    end

    // watchdog on a stuck handshake
    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        raw_x = '0;
        raw_y = '0;
        raw_z = '0;
        fail_cnt = 0;
        idle_cycles = 0;
        burst_left = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_zero_denominator();
        test_prerotate();
        wait_drained();
        test_random(1250);
        wait_drained();
        repeat (DRAIN) @(posedge clk);

        if (fail_cnt == 0 && angles_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
